>>> rtl/core/olst_pkg.sv
`default_nettype none

package olst_pkg;

  // Word width is fixed by the payload format; depth is a top-level parameter.
  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 64;

  // Operation codes carried in the mode field
  localparam logic [2:0] MODE_PUSH_FRONT  = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK   = 3'd1;
  localparam logic [2:0] MODE_READ_AT     = 3'd2;
  localparam logic [2:0] MODE_ERASE_AT    = 3'd3;
  localparam logic [2:0] MODE_ERASE_VALUE = 3'd4;
  localparam logic [2:0] MODE_FIND        = 3'd5;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] value;
    logic [5:0]               index;
  } olst_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_data;
    logic [5:0]               position;
    logic [6:0]               count;
  } olst_out_t;

  // What every cell does in a given cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_APPEND,
    CELL_ERASE,
    CELL_MATCH
  } olst_cell_op_t;

  typedef struct packed {
    olst_cell_op_t     op;
    logic [DATA_W-1:0] key;
  } olst_cell_ctl_t;

  typedef struct packed {
    logic done;
    logic found;
  } olst_scan_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_SCAN,
    ST_WIN,
    ST_ERASE
  } olst_state_t;

  // Lowest set bit of an 8-bit group
  function automatic logic [2:0] first_set8(input logic [7:0] v);
    logic [2:0] p;
    p = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        p = 3'(i);
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/olst_cell.sv
`default_nettype none

module olst_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  wire                          clk,
  input  olst_pkg::olst_cell_ctl_t     ctl,
  input  wire [CW-1:0]                 cmp_at,
  input  wire [olst_pkg::DATA_W-1:0]   lower_i,
  input  wire [olst_pkg::DATA_W-1:0]   upper_i,
  output logic [olst_pkg::DATA_W-1:0]  data_o,
  output logic                         match_o
);
  import olst_pkg::*;

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              match_r, match_nxt;

  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    unique case (ctl.op)
      CELL_HOLD: ;
      CELL_PUSH_FRONT: data_nxt = lower_i;
      CELL_APPEND: begin
        if (CW'(IDX) == cmp_at) begin
          data_nxt = ctl.key;
        end
      end
      CELL_ERASE: begin
        // entries at and above the hole close up
        if (CW'(IDX) >= cmp_at) begin
          data_nxt = upper_i;
        end
      end
      CELL_MATCH: match_nxt = (data_r == ctl.key) && (CW'(IDX) < cmp_at);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign data_o  = data_r;
  assign match_o = match_r;

endmodule

`default_nettype wire

>>> rtl/core/olst_scan.sv
`default_nettype none

module olst_scan #(
  parameter int DEPTH = 64,
  parameter int PW    = 6
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    go,
  input  wire [DEPTH-1:0]        match_i,
  output olst_pkg::olst_scan_t   res,
  output logic [PW-1:0]          pos_o
);
  import olst_pkg::*;

  localparam int NG = (DEPTH + 7) / 8;
  localparam int VW = NG * 8;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;

  logic [VW-1:0] vec_r, vec_nxt;
  logic [GW-1:0] grp_r, grp_nxt;
  logic          active_r, active_nxt;
  logic [7:0]    low;
  logic          hit, last;
  logic [GW+2:0] pos_full;

  // match vector moves down one group of eight per cycle
  assign low  = vec_r[7:0];
  assign hit  = |low;
  assign last = (grp_r == GW'(NG - 1));

  assign res.done  = active_r && (hit || last);
  assign res.found = active_r && hit;

  assign pos_full = {grp_r, first_set8(low)};
  assign pos_o    = pos_full[PW-1:0];

  always_comb begin
    vec_nxt    = vec_r;
    grp_nxt    = grp_r;
    active_nxt = active_r;
    if (go) begin
      vec_nxt    = VW'(match_i);
      grp_nxt    = '0;
      active_nxt = 1'b1;
    end else if (res.done) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      vec_nxt = vec_r >> 8;
      grp_nxt = grp_r + GW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
    grp_r <= grp_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/core/ordered_list_store_core.sv
`default_nettype none

// Bounded ordered list of signed words held in a chain of DEPTH cells.
// Input: an item (mode, value, index) is taken at a clock edge with start high
// and busy low. Output: every item gives exactly one result beat on out_item,
// flagged by out_strobe for one cycle; the receiver cannot stall it.
// States an item passes through after the accepting edge, before its strobe:
//   push front/back, erase at, refused or unused modes : EXEC
//   read at                                            : EXEC (window load), WIN (select),
//                                                        EXEC alone on a bad index
//   find                                               : EXEC (compare), LOAD, SCAN to a hit,
//                                                        or through the last group on a miss
//   erase value                                        : as find, then ERASE on a hit
// The cells shift or compare all entries in the same cycle; the first-match search
// walks the match bits eight per cycle, which sets the find/erase value time.
// busy drops in the strobe cycle, so the next item can be taken there.
// Reset (rst_n low, synchronous) empties the list; stored words are not cleared,
// only entries below the count are ever read.
module ordered_list_store_core #(
  parameter int DEPTH = olst_pkg::DEPTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  olst_pkg::olst_in_t    in_item,
  output logic                  out_strobe,
  output olst_pkg::olst_out_t   out_item
);
  import olst_pkg::*;

  localparam int CW    = $clog2(DEPTH + 1);       // count width
  localparam int PW    = $clog2(DEPTH);           // position width
  localparam int NG    = (DEPTH + 7) / 8;         // groups of eight cells
  localparam int GW    = (NG > 1) ? $clog2(NG) : 1;
  localparam int PADN  = 1 << (GW + 3);
  localparam int CMPW0 = (CW > 7) ? CW : 7;
  localparam int CMPW  = (CMPW0 > GW + 3) ? CMPW0 : GW + 3;

  olst_state_t        state_r, state_nxt;
  olst_in_t           cmd_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [DATA_W-1:0]  win_r [8];
  logic               out_strobe_r;
  olst_out_t          out_item_r;

  // cell chain
  olst_cell_ctl_t     cell_ctl;
  olst_cell_op_t      cell_op;
  logic [CW-1:0]      cell_at;
  logic [DATA_W-1:0]  cell_q [DEPTH];
  logic [DATA_W-1:0]  pad_q  [PADN];
  logic [DEPTH-1:0]   cell_match;

  // search
  logic               scan_go;
  olst_scan_t         scan_res;
  logic [PW-1:0]      scan_pos;

  // finish of an item
  logic                     fin;
  logic [1:0]               fin_status;
  logic signed [DATA_W-1:0] fin_rd;
  logic [PW-1:0]            fin_pos;
  logic                     win_load;

  logic [CMPW-1:0] idx_w, cnt_w, at_w, fin_pos_w, cnt_nxt_w;
  logic            full, bad_idx;
  logic [GW-1:0]   win_grp;

  assign idx_w     = CMPW'(cmd_r.index);
  assign cnt_w     = CMPW'(count_r);
  assign fin_pos_w = CMPW'(fin_pos);
  assign cnt_nxt_w = CMPW'(count_nxt);
  assign full      = (count_r == CW'(DEPTH));
  assign bad_idx   = (idx_w >= cnt_w);
  assign win_grp   = idx_w[GW+2:3];

  assign busy = (state_r != ST_IDLE);

  assign cell_ctl.op  = cell_op;
  assign cell_ctl.key = cmd_r.value;
  assign cell_at      = at_w[CW-1:0];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_W-1:0] lower, upper;
    if (k == 0) begin : g_first
      assign lower = cell_ctl.key;      // push front enters here
    end else begin : g_mid_lo
      assign lower = cell_q[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_q[k+1];
    end
    olst_cell #(
      .IDX (k),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .ctl     (cell_ctl),
      .cmp_at  (cell_at),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_q[k]),
      .match_o (cell_match[k])
    );
  end

  for (genvar k = 0; k < PADN; k++) begin : g_pad
    if (k < DEPTH) begin : g_real
      assign pad_q[k] = cell_q[k];
    end else begin : g_zero
      assign pad_q[k] = '0;
    end
  end

  olst_scan #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (scan_go),
    .match_i (cell_match),
    .res     (scan_res),
    .pos_o   (scan_pos)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cmd_r.mode) inside
          MODE_READ_AT:            state_nxt = bad_idx ? ST_IDLE : ST_WIN;
          MODE_ERASE_VALUE,
          MODE_FIND:               state_nxt = ST_LOAD;
          default:                 state_nxt = ST_IDLE;
        endcase
      end
      ST_LOAD: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.found && (cmd_r.mode == MODE_ERASE_VALUE)) begin
            state_nxt = ST_ERASE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_WIN:   state_nxt = ST_IDLE;
      ST_ERASE: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cell_op    = CELL_HOLD;
    at_w       = cnt_w;
    scan_go    = 1'b0;
    fin        = 1'b0;
    fin_status = STAT_OK;
    fin_rd     = '0;
    fin_pos    = '0;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    win_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_EXEC: begin
        unique case (cmd_r.mode) inside
          MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            fin = 1'b1;
            if (full) begin
              fin_status = STAT_FULL;
            end else begin
              cell_op   = (cmd_r.mode == MODE_PUSH_FRONT) ? CELL_PUSH_FRONT : CELL_APPEND;
              count_nxt = count_r + CW'(1);
            end
          end
          MODE_READ_AT: begin
            if (bad_idx) begin
              fin        = 1'b1;
              fin_status = STAT_BAD_INDEX;
            end else begin
              win_load = 1'b1;
            end
          end
          MODE_ERASE_AT: begin
            fin = 1'b1;
            if (bad_idx) begin
              fin_status = STAT_BAD_INDEX;
            end else begin
              cell_op   = CELL_ERASE;
              at_w      = idx_w;
              count_nxt = count_r - CW'(1);
            end
          end
          MODE_ERASE_VALUE, MODE_FIND: begin
            cell_op = CELL_MATCH;   // compare against entries below the count
          end
          default: fin = 1'b1;      // unused modes: plain ok beat
        endcase
      end
      ST_LOAD: scan_go = 1'b1;
      ST_SCAN: begin
        if (scan_res.done) begin
          pos_nxt = scan_pos;
          if (!scan_res.found) begin
            fin        = 1'b1;
            fin_status = STAT_NOT_FOUND;
          end else if (cmd_r.mode == MODE_FIND) begin
            fin     = 1'b1;
            fin_pos = scan_pos;
          end
        end
      end
      ST_WIN: begin
        fin    = 1'b1;
        fin_rd = $signed(win_r[cmd_r.index[2:0]]);
      end
      ST_ERASE: begin
        fin       = 1'b1;
        fin_pos   = pos_r;
        cell_op   = CELL_ERASE;
        at_w      = CMPW'(pos_r);
        count_nxt = count_r - CW'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= in_item;
    end
    pos_r <= pos_nxt;
    // first level of the read select: the group of eight holding the index
    if (win_load) begin
      for (int j = 0; j < 8; j++) begin
        win_r[j] <= pad_q[{win_grp, 3'(j)}];
      end
    end
    if (fin) begin
      out_item_r.status    <= fin_status;
      out_item_r.read_data <= fin_rd;
      out_item_r.position  <= fin_pos_w[5:0];
      out_item_r.count     <= cnt_nxt_w[6:0];
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire

>>> sim/ordered_list_store_core_tb.sv
module ordered_list_store_core_tb;
  import olst_pkg::*;

  // Depth used for this run; the full-list case is reached at this count.
  localparam int LIST_DEPTH = DEPTH_DEF;

  // The two mode codes the block treats as no-ops.
  localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

  // Random part length, in input beats.
  localparam int RANDOM_BEATS = 1050;

  // Longest run of cycles with no beat on either side before we give up.
  // Worst legit quiet stretch: a sender gap or a full-list value search.
  localparam int WATCHDOG_LIMIT = 200;

  typedef enum int {
    PH_FILL,
    PH_MIXED,
    PH_DRAIN,
    PH_NOISE
  } phase_t;

  // One row of the directed table: the beat, and a hand-typed result where
  // the answer is obvious; other rows take the shadow list's answer.
  typedef struct {
    olst_in_t  item;
    bit        typed;
    olst_out_t res;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  olst_in_t  in_item = '0;
  logic      out_strobe;
  olst_out_t out_item;

  // Shadow copy of the list contents, index 0 at the front.
  logic signed [DATA_W-1:0] shadow_words[$];

  // Results owed by the block, oldest first.
  olst_out_t pending_results[$];

  stim_row_t directed_rows[$];

  int mismatch_count = 0;
  int idle_cycles = 0;

  ordered_list_store_core #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one operation to the shadow list and returns the result beat
  // the block owes for it.
  function automatic olst_out_t next_list_result(input olst_in_t item);
    olst_out_t r;
    int        hit;
    r = '0;
    hit = -1;
    case (item.mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        // full list refuses the push and keeps its contents
        if (shadow_words.size() >= LIST_DEPTH) begin
          r.status = STAT_FULL;
        end else if (item.mode == MODE_PUSH_FRONT) begin
          shadow_words.push_front(item.value);
        end else begin
          shadow_words.push_back(item.value);
        end
      end
      MODE_READ_AT: begin
        if (item.index >= shadow_words.size()) begin
          r.status = STAT_BAD_INDEX;
        end else begin
          r.read_data = shadow_words[item.index];
        end
      end
      MODE_ERASE_AT: begin
        if (item.index >= shadow_words.size()) begin
          r.status = STAT_BAD_INDEX;
        end else begin
          shadow_words.delete(item.index);
        end
      end
      MODE_ERASE_VALUE, MODE_FIND: begin
        // first match from the front, full-width equality
        for (int k = 0; k < shadow_words.size(); k++) begin
          if (hit < 0 && shadow_words[k] == item.value) begin
            hit = k;
          end
        end
        if (hit < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          r.position = 6'(hit);
          if (item.mode == MODE_ERASE_VALUE) begin
            shadow_words.delete(hit);
          end
        end
      end
      default: begin
        // unused modes: no change, all-zero payload apart from count
      end
    endcase
    r.count = 7'(shadow_words.size());
    return r;
  endfunction

  task automatic row_known(input logic [2:0] mode, input logic [DATA_W-1:0] value,
                           input logic [5:0] index, input logic [1:0] status,
                           input logic [DATA_W-1:0] rdata, input logic [5:0] pos,
                           input logic [6:0] cnt);
    stim_row_t row;
    row.item = '{mode: mode, value: value, index: index};
    row.typed = 1'b1;
    row.res = '{status: status, read_data: rdata, position: pos, count: cnt};
    directed_rows.push_back(row);
  endtask

  task automatic row_pred(input logic [2:0] mode, input logic [DATA_W-1:0] value,
                          input logic [5:0] index);
    stim_row_t row;
    row.item = '{mode: mode, value: value, index: index};
    row.typed = 1'b0;
    row.res = '0;
    directed_rows.push_back(row);
  endtask

  // Offers one beat and holds it until taken (start high, busy low at an
  // edge). start is left high so a back-to-back beat needs no toggle.
  task automatic send_beat(input olst_in_t item, input bit typed,
                           input olst_out_t known);
    olst_out_t predicted;
    start <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    // shadow list always advances, even when the result is typed in
    predicted = next_list_result(item);
    pending_results.push_back(typed ? known : predicted);
  endtask

  task automatic idle_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold the sender off until every owed result beat has come back.
  task automatic drain_results;
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Result side: the block cannot be stalled, so every strobe is a beat.
  // Sampled at the edge, before the block's own updates land.
  always @(posedge clk) begin
    olst_out_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no outstanding item");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          mismatch_count++;
        end
        if (out_item.read_data !== want.read_data) begin
          $error("read_data: expected %0d, got %0d", want.read_data,
                 out_item.read_data);
          mismatch_count++;
        end
        if (out_item.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position,
                 out_item.position);
          mismatch_count++;
        end
        if (out_item.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_item.count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any beat on either side resets it.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("watchdog: no beat for %0d cycles, %0d results owed",
             idle_cycles, pending_results.size());
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    olst_in_t  item;
    olst_out_t none;
    phase_t    phase;
    int        phase_left;
    int        burst_left;
    int        sent;
    int        roll;
    int        held;
    none = '0;

    // Directed table, walked from an empty list.
    row_known(MODE_READ_AT, 32'h0000_0000, 6'd0, STAT_BAD_INDEX, '0, '0, 7'd0);
    row_known(MODE_FIND, 32'h0000_0000, 6'd0, STAT_NOT_FOUND, '0, '0, 7'd0);
    row_known(MODE_ERASE_VALUE, 32'h8000_0000, 6'd0, STAT_NOT_FOUND, '0, '0, 7'd0);
    row_known(MODE_ERASE_AT, 32'h0000_0000, 6'd63, STAT_BAD_INDEX, '0, '0, 7'd0);
    row_known(MODE_PUSH_BACK, 32'h7fff_ffff, 6'd0, STAT_OK, '0, '0, 7'd1);
    row_known(MODE_PUSH_FRONT, 32'h8000_0000, 6'd63, STAT_OK, '0, '0, 7'd2);
    row_known(MODE_PUSH_BACK, 32'hffff_ffff, 6'd21, STAT_OK, '0, '0, 7'd3);
    row_known(MODE_PUSH_BACK, 32'h0000_0000, 6'd42, STAT_OK, '0, '0, 7'd4);
    row_known(MODE_READ_AT, 32'h0000_0000, 6'd0, STAT_OK, 32'h8000_0000, '0, 7'd4);
    // index equal to the count is one past the end
    row_known(MODE_READ_AT, 32'h0000_0000, 6'd4, STAT_BAD_INDEX, '0, '0, 7'd4);
    row_pred(MODE_READ_AT, 32'hffff_ffff, 6'd3);
    row_pred(MODE_FIND, 32'hffff_ffff, 6'd0);
    row_pred(MODE_FIND, 32'h7fff_ffff, 6'd63);
    row_pred(MODE_ERASE_VALUE, 32'hffff_ffff, 6'd0);
    row_pred(MODE_ERASE_AT, 32'h0000_0000, 6'd0);
    // duplicates: erase value must take the front-most copy
    row_pred(MODE_PUSH_FRONT, 32'h0000_0005, 6'd0);
    row_pred(MODE_PUSH_FRONT, 32'h0000_0005, 6'd0);
    row_pred(MODE_ERASE_VALUE, 32'h0000_0005, 6'd0);
    row_pred(MODE_FIND, 32'h0000_0005, 6'd0);
    row_pred(MODE_FIND, 32'h0000_0000, 6'd0);
    row_pred(MODE_UNUSED_6, 32'hffff_ffff, 6'd63);
    row_pred(MODE_UNUSED_7, 32'h0000_0000, 6'd0);
    row_pred(MODE_ERASE_AT, 32'h0000_0000, 6'd63);
    row_pred(MODE_READ_AT, 32'h0000_0000, 6'd2);

    // Reset once, synchronous.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
    end
    drain_results();

    // Random part: phases steer the count up to full and back down to empty,
    // with about half of the values taken from what is held so finds and erases hit.
    sent = 0;
    burst_left = 0;
    phase = PH_FILL;
    while (sent < RANDOM_BEATS) begin
      phase_left = $urandom_range(120, 20);
      while (phase_left > 0 && sent < RANDOM_BEATS) begin
        held = shadow_words.size();
        roll = $urandom_range(99, 0);
        case (phase)
          PH_FILL: begin
            if (roll < 45) item.mode = MODE_PUSH_FRONT;
            else if (roll < 88) item.mode = MODE_PUSH_BACK;
            else item.mode = 3'($urandom_range(MODE_FIND, MODE_READ_AT));
          end
          PH_DRAIN: begin
            if (roll < 30) item.mode = MODE_ERASE_AT;
            else if (roll < 60) item.mode = MODE_ERASE_VALUE;
            else if (roll < 75) item.mode = MODE_READ_AT;
            else if (roll < 90) item.mode = MODE_FIND;
            else item.mode = 3'($urandom_range(MODE_PUSH_BACK, MODE_PUSH_FRONT));
          end
          PH_MIXED: begin
            if (roll < 3) item.mode = MODE_UNUSED_6;
            else if (roll < 6) item.mode = MODE_UNUSED_7;
            else item.mode = 3'($urandom_range(MODE_FIND, MODE_PUSH_FRONT));
          end
          default: begin
            item.mode = 3'($urandom_range(MODE_UNUSED_7, MODE_PUSH_FRONT));
          end
        endcase
        if (phase == PH_NOISE) begin
          item.value = $urandom;
          item.index = 6'($urandom_range(63, 0));
        end else begin
          roll = $urandom_range(99, 0);
          if (roll < 50 && held > 0) begin
            item.value = shadow_words[$urandom_range(held - 1, 0)];
          end else if (roll < 65) begin
            // small pool: builds up duplicate entries
            item.value = $urandom_range(7, 0);
          end else if (roll < 72) begin
            case ($urandom_range(3, 0))
              0: item.value = 32'h8000_0000;
              1: item.value = 32'h7fff_ffff;
              2: item.value = 32'hffff_ffff;
              default: item.value = 32'h0000_0000;
            endcase
          end else begin
            item.value = $urandom;
          end
          if (held > 0 && $urandom_range(3, 0) != 0) begin
            item.index = 6'($urandom_range(held - 1, 0));
          end else begin
            item.index = 6'($urandom_range(63, 0));
          end
        end

        // sender bursts: short bursts with gaps, now and then a long
        // gap-free stretch
        if (burst_left == 0) begin
          if ($urandom_range(9, 0) == 0) begin
            burst_left = 150;
          end else begin
            burst_left = $urandom_range(25, 1);
            idle_gap($urandom_range(6, 1));
          end
        end
        send_beat(item, 1'b0, none);
        burst_left--;
        phase_left--;
        sent++;
      end
      // after fill (else one time in four) wait for every answer, then pick a phase
      if (phase == PH_FILL || $urandom_range(3, 0) == 0) begin
        drain_results();
      end
      roll = $urandom_range(9, 0);
      if (roll < 3) phase = PH_FILL;
      else if (roll < 6) phase = PH_DRAIN;
      else if (roll < 9) phase = PH_MIXED;
      else phase = PH_NOISE;
    end

    // Wind down: everything answered, then a wait for stray beats.
    drain_results();
    repeat (16) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> ordered_list_store_core.f
rtl/core/olst_pkg.sv
rtl/core/olst_cell.sv
rtl/core/olst_scan.sv
rtl/core/ordered_list_store_core.sv
sim/ordered_list_store_core_tb.sv
